// ===== hdl/ping_slot_replacement_picker_macros.svh =====
`ifndef PING_SLOT_REPLACEMENT_PICKER_MACROS_SVH
`define PING_SLOT_REPLACEMENT_PICKER_MACROS_SVH

// same-cycle implication
`define PSRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/psrp_pkg.sv =====
`default_nettype none

package psrp_pkg;

  localparam int SLOTS_DEF = 32;

  localparam int TIME_W = 32;
  localparam int SLOT_W = 5;
  localparam int WHY_W  = 2;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 40;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  localparam logic [WHY_W-1:0] WHY_FREE      = 2'd0;
  localparam logic [WHY_W-1:0] WHY_EXPIRED   = 2'd1;
  localparam logic [WHY_W-1:0] WHY_COMPLETED = 2'd2;
  localparam logic [WHY_W-1:0] WHY_PENDING   = 2'd3;

endpackage

`default_nettype wire

// ===== hdl/ping_slot_replacement_picker.sv =====
`default_nettype none
// Slot replacement picker: one request on the input is either a write of one slot
// (tuser = 0) or a select (tuser = 1) that names a slot to reuse at time "now", in the
// order lowest free, oldest expired pending, oldest completed, oldest pending, ties to
// the lowest index. Exactly one result per request. A write goes straight to the finish
// state; a select first scans the start/timeout memory, reading one slot per cycle
// into a single age subtract and compare unit, and then goes to the finish state.
// The input is not ready while a request is in work; a finished result waits in the
// output register without blocking the next request.
module ping_slot_replacement_picker #(
  parameter int SLOTS = psrp_pkg::SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  // [4:0] slot, [5] occupied_flag, [37:6] start_time, [69:38] timeout_ticks,
  // [101:70] result_time, [133:102] now, [135:134] zero
  input  wire logic [psrp_pkg::IN_DATA_W-1:0] in_tdata,
  // [0] opcode
  input  wire logic                           in_tuser,
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  // [0] ok, [5:1] chosen_slot, [7:6] why, [39:8] slot_age
  output      logic [psrp_pkg::OUT_DATA_W-1:0] out_tdata
);
  import psrp_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [1:0] TRK_EXP = 2'd0;
  localparam logic [1:0] TRK_CMP = 2'd1;
  localparam logic [1:0] TRK_PND = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [SLOTS-1:0] busy_r, busy_nxt;
  logic [SLOTS-1:0] done_r, done_nxt;

  logic [TIME_W-1:0] begin_mem [SLOTS];
  logic [TIME_W-1:0] limit_mem [SLOTS];
  logic [TIME_W-1:0] begin_rd_r, limit_rd_r;

  logic              mem_we;
  logic [IW-1:0]     wr_idx;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;

  logic [IW:0]       cnt_r, cnt_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;

  logic              p1_vld_r, p1_vld_nxt;
  logic [IW-1:0]     p1_idx_r, p1_idx_nxt;

  logic              p2_vld_r, p2_vld_nxt;
  logic [IW-1:0]     p2_idx_r, p2_idx_nxt;
  logic [TIME_W-1:0] p2_age_r, p2_age_nxt;
  logic [TIME_W-1:0] p2_limit_r, p2_limit_nxt;
  logic              p2_busy_r, p2_busy_nxt;
  logic              p2_done_r, p2_done_nxt;

  logic              free_fnd_r, free_fnd_nxt;
  logic [IW-1:0]     free_idx_r, free_idx_nxt;
  logic [2:0]        fnd_r, fnd_nxt;
  logic [IW-1:0]     bidx_r [3];
  logic [IW-1:0]     bidx_nxt [3];
  logic [TIME_W-1:0] bage_r [3];
  logic [TIME_W-1:0] bage_nxt [3];

  logic              res_ok_r, res_ok_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [WHY_W-1:0]  res_why_r, res_why_nxt;
  logic [TIME_W-1:0] res_age_r, res_age_nxt;

  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic              in_acc;
  logic              in_op;
  logic [SLOT_W-1:0] in_slot;
  logic              in_occ;
  logic [TIME_W-1:0] in_start, in_timeout, in_result, in_now;
  logic              wr_ok;
  logic              scan_issued;
  logic [1:0]        cls;

  assign in_op      = in_tuser;
  assign in_slot    = in_tdata[4:0];
  assign in_occ     = in_tdata[5];
  assign in_start   = in_tdata[37:6];
  assign in_timeout = in_tdata[69:38];
  assign in_result  = in_tdata[101:70];
  assign in_now     = in_tdata[133:102];

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  assign wr_ok       = !in_result[TIME_W-1] && (32'(in_slot) < 32'(SLOTS));
  assign wr_idx      = IW'(in_slot);
  assign mem_we      = in_acc && (in_op == OP_WRITE) && wr_ok;
  assign scan_issued = (cnt_r == (IW+1)'(SLOTS));
  assign rd_en       = (state_r == S_SCAN) && !scan_issued;
  assign rd_addr     = cnt_r[IW-1:0];

  assign cls = !p2_done_r ? ((p2_age_r >= p2_limit_r) ? TRK_EXP : TRK_PND) : TRK_CMP;

  always_comb begin
    state_nxt      = state_r;
    busy_nxt       = busy_r;
    done_nxt       = done_r;
    cnt_nxt        = cnt_r;
    now_nxt        = now_r;
    p1_vld_nxt     = 1'b0;
    p1_idx_nxt     = p1_idx_r;
    p2_vld_nxt     = 1'b0;
    p2_idx_nxt     = p2_idx_r;
    p2_age_nxt     = p2_age_r;
    p2_limit_nxt   = p2_limit_r;
    p2_busy_nxt    = p2_busy_r;
    p2_done_nxt    = p2_done_r;
    free_fnd_nxt   = free_fnd_r;
    free_idx_nxt   = free_idx_r;
    fnd_nxt        = fnd_r;
    bidx_nxt       = bidx_r;
    bage_nxt       = bage_r;
    res_ok_nxt     = res_ok_r;
    res_slot_nxt   = res_slot_r;
    res_why_nxt    = res_why_r;
    res_age_nxt    = res_age_r;
    out_tvalid_nxt = out_tvalid_r;
    out_data_nxt   = out_data_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          now_nxt = in_now;
          if (in_op == OP_WRITE) begin
            res_ok_nxt   = wr_ok;
            res_slot_nxt = wr_ok ? in_slot : '0;
            res_why_nxt  = WHY_FREE;
            res_age_nxt  = '0;
            if (wr_ok) begin
              busy_nxt[wr_idx] = in_occ;
              done_nxt[wr_idx] = |in_result;
            end
            state_nxt = S_FIN;
          end else begin
            cnt_nxt      = '0;
            free_fnd_nxt = 1'b0;
            fnd_nxt      = '0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // issue one memory read
        if (rd_en) begin
          cnt_nxt    = cnt_r + 1'b1;
          p1_vld_nxt = 1'b1;
          p1_idx_nxt = rd_addr;
        end
        // age of the slot just read
        if (p1_vld_r) begin
          p2_vld_nxt   = 1'b1;
          p2_idx_nxt   = p1_idx_r;
          p2_age_nxt   = now_r - begin_rd_r;
          p2_limit_nxt = limit_rd_r;
          p2_busy_nxt  = busy_r[p1_idx_r];
          p2_done_nxt  = done_r[p1_idx_r];
        end
        // running best per class
        if (p2_vld_r) begin
          if (!p2_busy_r) begin
            if (!free_fnd_r) begin
              free_fnd_nxt = 1'b1;
              free_idx_nxt = p2_idx_r;
            end
          end else if (!fnd_r[cls] || (p2_age_r > bage_r[cls])) begin
            fnd_nxt[cls]  = 1'b1;
            bidx_nxt[cls] = p2_idx_r;
            bage_nxt[cls] = p2_age_r;
          end
        end
        if (scan_issued && !p1_vld_r && !p2_vld_r) begin
          res_ok_nxt   = 1'b1;
          res_slot_nxt = '0;
          res_why_nxt  = WHY_FREE;
          res_age_nxt  = '0;
          priority if (free_fnd_r) begin
            res_slot_nxt = SLOT_W'(free_idx_r);
          end else if (fnd_r[TRK_EXP]) begin
            res_slot_nxt = SLOT_W'(bidx_r[TRK_EXP]);
            res_why_nxt  = WHY_EXPIRED;
            res_age_nxt  = bage_r[TRK_EXP];
          end else if (fnd_r[TRK_CMP]) begin
            res_slot_nxt = SLOT_W'(bidx_r[TRK_CMP]);
            res_why_nxt  = WHY_COMPLETED;
            res_age_nxt  = bage_r[TRK_CMP];
          end else if (fnd_r[TRK_PND]) begin
            res_slot_nxt = SLOT_W'(bidx_r[TRK_PND]);
            res_why_nxt  = WHY_PENDING;
            res_age_nxt  = bage_r[TRK_PND];
          end else begin
            res_ok_nxt = 1'b0;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = {res_age_r, res_why_r, res_slot_r, res_ok_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      busy_r       <= '0;
      done_r       <= '0;
      cnt_r        <= '0;
      p1_vld_r     <= 1'b0;
      p2_vld_r     <= 1'b0;
      free_fnd_r   <= 1'b0;
      fnd_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      busy_r       <= busy_nxt;
      done_r       <= done_nxt;
      cnt_r        <= cnt_nxt;
      p1_vld_r     <= p1_vld_nxt;
      p2_vld_r     <= p2_vld_nxt;
      free_fnd_r   <= free_fnd_nxt;
      fnd_r        <= fnd_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    p1_idx_r   <= p1_idx_nxt;
    p2_idx_r   <= p2_idx_nxt;
    p2_age_r   <= p2_age_nxt;
    p2_limit_r <= p2_limit_nxt;
    p2_busy_r  <= p2_busy_nxt;
    p2_done_r  <= p2_done_nxt;
    free_idx_r <= free_idx_nxt;
    bidx_r     <= bidx_nxt;
    bage_r     <= bage_nxt;
    res_ok_r   <= res_ok_nxt;
    res_slot_r <= res_slot_nxt;
    res_why_r  <= res_why_nxt;
    res_age_r  <= res_age_nxt;
    out_data_r <= out_data_nxt;
  end

  // start / timeout memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      begin_mem[wr_idx] <= in_start;
      limit_mem[wr_idx] <= in_timeout;
    end
    if (rd_en) begin
      begin_rd_r <= begin_mem[rd_addr];
      limit_rd_r <= limit_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/psrp_checker.sv =====
`default_nettype none
`include "ping_slot_replacement_picker_macros.svh"

module psrp_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [psrp_pkg::OUT_DATA_W-1:0] out_tdata
);
  import psrp_pkg::*;

  `PSRP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `PSRP_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "ready right after a request was taken")
  `PSRP_ASSERT_NOW(a_why_needs_ok, out_tvalid && (out_tdata[7:6] != WHY_FREE), out_tdata[0], "reason given without ok")
  `PSRP_ASSERT_NOW(a_fail_zero, out_tvalid && !out_tdata[0], out_tdata[39:1] == '0, "failed result carries data")

endmodule

bind ping_slot_replacement_picker psrp_checker u_psrp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
